// ===== rtl/core/tstg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tstg_pkg;

  localparam int FREQ_W    = 16;
  localparam int MS_W      = 16;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Request kinds carried on in_tuser.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // Limit register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_HI  = 2'd3;

  localparam logic [CFG_W-1:0] FREQ_LO_RST = 16'd100;
  localparam logic [CFG_W-1:0] FREQ_HI_RST = 16'd5000;
  localparam logic [CFG_W-1:0] DUR_LO_RST  = 16'd10;
  localparam logic [CFG_W-1:0] DUR_HI_RST  = 16'd5000;

  typedef struct packed {
    logic tick;
    logic stop;
    logic div_start;
    logic load;
    logic out_load;
    logic refuse;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tstg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tstg_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic [tstg_pkg::REQ_W-1:0] in_type,
  output logic                            in_tready,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  input  wire tstg_pkg::status_t          status,
  output tstg_pkg::cmd_t                  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_type)
            tstg_pkg::REQ_TICK: begin
              cmd.tick     = 1'b1;
              cmd.out_load = 1'b1;
            end
            tstg_pkg::REQ_STOP: begin
              cmd.stop     = 1'b1;
              cmd.out_load = 1'b1;
            end
            tstg_pkg::REQ_START: begin
              if (status.range_ok) begin
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV;
              end else begin
                cmd.out_load = 1'b1;
                cmd.refuse   = 1'b1;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        // The new tone is committed only once the result slot is free.
        if (status.div_done && out_free) begin
          cmd.load     = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !in_tready)
    else $error("input taken while the divider runs");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before its beat was taken");

  a_div_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !status.div_done) |=> (state_r == S_DIV))
    else $error("left the divide state before the quotient was ready");

endmodule

`default_nettype wire

// ===== rtl/core/tstg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tstg_dp #(
  parameter int TICK_HZ = 1000000
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tstg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tstg_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic [tstg_pkg::FREQ_W-1:0]    in_freq,
  input  wire logic [tstg_pkg::MS_W-1:0]      in_ms,
  input  wire tstg_pkg::cmd_t                 cmd,
  output tstg_pkg::status_t                   status,
  output logic                                out_pin,
  output logic                                out_on,
  output logic                                out_refused
);

  localparam int PW  = $clog2(TICK_HZ + 1);
  localparam int CW  = $clog2(PW + 1);
  localparam int TPM = TICK_HZ / 1000;
  localparam int TW  = (TPM > 1) ? $clog2(TPM) : 1;
  localparam int FW  = tstg_pkg::FREQ_W;
  localparam int MW  = tstg_pkg::MS_W;

  localparam logic [PW-1:0] TICK_V = TICK_HZ[PW-1:0];
  localparam logic [TW:0]   TPM_V  = TPM[TW:0];

  // Limit registers.
  logic [FW-1:0] freq_lo_r, freq_hi_r;
  logic [MW-1:0] dur_lo_r, dur_hi_r;

  // Tone state.
  logic          playing_r, playing_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [PW-1:0] high_r, high_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [MW-1:0] ms_left_r, ms_left_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [MW-1:0] req_ms_r;

  // Restoring divider for TICK_HZ / frequency, one quotient bit a cycle.
  logic [FW-1:0] div_r;
  logic [PW-1:0] dvd_r;
  logic [FW-1:0] rem_r;
  logic [PW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [FW:0]   rem_sh;
  logic [FW:0]   rem_diff;
  logic          rem_ge;

  logic [TW:0]   tick_sum;
  logic [MW-1:0] ms_dec;
  logic [PW-1:0] q_eff;

  assign status.range_ok = (in_freq != '0) && (in_freq >= freq_lo_r) &&
                           (in_freq <= freq_hi_r) && (in_ms >= dur_lo_r) &&
                           (in_ms <= dur_hi_r);
  assign status.div_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_lo_r <= tstg_pkg::FREQ_LO_RST;
      freq_hi_r <= tstg_pkg::FREQ_HI_RST;
      dur_lo_r  <= tstg_pkg::DUR_LO_RST;
      dur_hi_r  <= tstg_pkg::DUR_HI_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tstg_pkg::CFG_FREQ_LO: freq_lo_r <= cfg_wdata;
        tstg_pkg::CFG_FREQ_HI: freq_hi_r <= cfg_wdata;
        tstg_pkg::CFG_DUR_LO:  dur_lo_r  <= cfg_wdata;
        tstg_pkg::CFG_DUR_HI:  dur_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rem_sh   = {rem_r, dvd_r[PW-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign rem_ge   = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(PW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_r    <= in_freq;
      req_ms_r <= in_ms;
      dvd_r    <= TICK_V;
      rem_r    <= '0;
      q_r      <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[PW-2:0], 1'b0};
      rem_r <= rem_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
      q_r   <= {q_r[PW-2:0], rem_ge};
    end
  end

  // A frequency above the tick rate gives a zero quotient, taken as one.
  assign q_eff    = (q_r == '0) ? PW'(1) : q_r;
  assign tick_sum = {1'b0, tick_r} + 1'b1;
  assign ms_dec   = (ms_left_r != '0) ? (ms_left_r - 1'b1) : ms_left_r;

  always_comb begin
    playing_nxt = playing_r;
    top_nxt     = top_r;
    high_nxt    = high_r;
    phase_nxt   = phase_r;
    ms_left_nxt = ms_left_r;
    tick_nxt    = tick_r;
    if (cmd.tick && playing_r) begin
      phase_nxt = (phase_r >= top_r) ? '0 : (phase_r + 1'b1);
      if (tick_sum >= TPM_V) begin
        tick_nxt    = '0;
        ms_left_nxt = ms_dec;
        if (ms_dec == '0) begin
          playing_nxt = 1'b0;
          phase_nxt   = '0;
        end
      end else begin
        tick_nxt = tick_sum[TW-1:0];
      end
    end
    if (cmd.stop) begin
      playing_nxt = 1'b0;
      phase_nxt   = '0;
      ms_left_nxt = '0;
      tick_nxt    = '0;
    end
    if (cmd.load) begin
      top_nxt     = q_eff - 1'b1;
      high_nxt    = q_eff >> 1;
      phase_nxt   = '0;
      tick_nxt    = '0;
      ms_left_nxt = req_ms_r;
      playing_nxt = (req_ms_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      top_r     <= '0;
      high_r    <= '0;
      phase_r   <= '0;
      ms_left_r <= '0;
      tick_r    <= '0;
    end else begin
      playing_r <= playing_nxt;
      top_r     <= top_nxt;
      high_r    <= high_nxt;
      phase_r   <= phase_nxt;
      ms_left_r <= ms_left_nxt;
      tick_r    <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pin     <= playing_nxt && (phase_nxt < high_nxt);
      out_on      <= playing_nxt;
      out_refused <= cmd.refuse;
    end
  end

  a_silent_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    !playing_r |-> (phase_r == '0 && ms_left_r == '0 && tick_r == '0))
    else $error("counters left running while silent");

  a_playing_has_time : assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (ms_left_r != '0))
    else $error("tone playing with no milliseconds left");

endmodule

`default_nettype wire

// ===== rtl/core/timed_square_tone_generator.sv =====
// A tick, stop or unused request, or a refused start, gives its beat in the cycle after acceptance.
// A start request that passes the limit check runs the bit-serial divider, whose quotient width
// is PW = clog2(TICK_HZ + 1); its beat is loaded once the quotient is done and the slot is free.
// One tick or stop beat per cycle while results are taken; no input is taken while the divider runs.
// Reset (synchronous, active low): silent, all counters zero, limits 100/5000 Hz and 10/5000 ms.
`timescale 1ns / 1ps
`default_nettype none

module timed_square_tone_generator #(
  parameter int TICK_HZ = 1000000
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tone_freq_hz [15:0], tone_ms [31:16]
  input  wire logic [31:0]                    in_tdata,
  // req_type [1:0]
  input  wire logic [tstg_pkg::REQ_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pin_level [0], tone_on [1], zero [7:2]
  output logic [7:0]                          out_tdata,
  // refused [0]
  output logic                                out_tuser,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tstg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tstg_pkg::CFG_W-1:0]     cfg_wdata
);

  tstg_pkg::cmd_t    cmd;
  tstg_pkg::status_t status;
  logic              pin;
  logic              on;

  tstg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_type    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tstg_dp #(
    .TICK_HZ (TICK_HZ)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_freq     (in_tdata[15:0]),
    .in_ms       (in_tdata[31:16]),
    .cmd         (cmd),
    .status      (status),
    .out_pin     (pin),
    .out_on      (on),
    .out_refused (out_tuser)
  );

  assign out_tdata = {6'd0, on, pin};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tstg_pkg::*;

  localparam int unsigned TIMER_HZ        = 1000000;
  localparam int unsigned TICKS_PER_MILLI = TIMER_HZ / 1000;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned DRAIN_CYCLES    = 30;

  // The request code that the block leaves unused.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // Limit sets used by the directed rows.
  localparam logic [1:0] SET_RESET    = 2'd0;
  localparam logic [1:0] SET_WIDE     = 2'd1;
  localparam logic [1:0] SET_INVERTED = 2'd2;

  typedef struct packed {
    logic pin;
    logic on;
    logic refused;
  } tone_result_t;

  typedef struct packed {
    logic [1:0]       setting;
    logic [REQ_W-1:0] req;
    logic [15:0]      freq;
    logic [15:0]      ms;
    logic             typed;
    tone_result_t     want;
  } tone_row_t;

  localparam tone_row_t DIRECTED [25] = '{
    '{SET_RESET,    REQ_TICK,  16'd0,     16'd0,     1'b1, 3'b000},
    '{SET_RESET,    REQ_STOP,  16'hFFFF,  16'hFFFF,  1'b1, 3'b000},
    '{SET_RESET,    REQ_SPARE, 16'd0,     16'd0,     1'b1, 3'b000},
    '{SET_RESET,    REQ_START, 16'd0,     16'd100,   1'b1, 3'b001},
    '{SET_RESET,    REQ_START, 16'd99,    16'd100,   1'b1, 3'b001},
    '{SET_RESET,    REQ_START, 16'd5001,  16'd100,   1'b1, 3'b001},
    '{SET_RESET,    REQ_START, 16'd1000,  16'd9,     1'b1, 3'b001},
    '{SET_RESET,    REQ_START, 16'd1000,  16'd5001,  1'b1, 3'b001},
    '{SET_RESET,    REQ_START, 16'd100,   16'd10,    1'b0, 3'b000},
    '{SET_RESET,    REQ_TICK,  16'd0,     16'd0,     1'b0, 3'b000},
    '{SET_RESET,    REQ_START, 16'd5000,  16'd5000,  1'b0, 3'b000},
    '{SET_RESET,    REQ_START, 16'd6000,  16'd20,    1'b0, 3'b000},
    '{SET_RESET,    REQ_SPARE, 16'd1,     16'd1,     1'b0, 3'b000},
    '{SET_RESET,    REQ_TICK,  16'd0,     16'd0,     1'b0, 3'b000},
    '{SET_RESET,    REQ_STOP,  16'd1,     16'd0,     1'b1, 3'b000},
    '{SET_WIDE,     REQ_START, 16'd0,     16'd5,     1'b1, 3'b001},
    '{SET_WIDE,     REQ_START, 16'hFFFF,  16'hFFFF,  1'b0, 3'b000},
    '{SET_WIDE,     REQ_TICK,  16'd0,     16'd0,     1'b0, 3'b000},
    '{SET_WIDE,     REQ_START, 16'd1,     16'd0,     1'b1, 3'b000},
    '{SET_WIDE,     REQ_START, 16'd1,     16'd1,     1'b0, 3'b000},
    '{SET_WIDE,     REQ_TICK,  16'd0,     16'd0,     1'b0, 3'b000},
    '{SET_WIDE,     REQ_START, 16'hFFFF,  16'd0,     1'b1, 3'b000},
    '{SET_INVERTED, REQ_START, 16'd1000,  16'd1000,  1'b1, 3'b001},
    '{SET_INVERTED, REQ_START, 16'd100,   16'd10,    1'b1, 3'b001},
    '{SET_INVERTED, REQ_TICK,  16'd0,     16'd0,     1'b1, 3'b000}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic [REQ_W-1:0]     in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Travels with each input beat: a hand-typed expectation replaces the predicted one.
  logic         beat_typed;
  tone_result_t beat_want;

  // Predicted tone state and limits.
  bit          tone_playing;
  bit [19:0]   top_count;
  bit [19:0]   high_count;
  bit [19:0]   phase;
  bit [15:0]   ms_remaining;
  bit [9:0]    ticks_this_ms;
  bit [15:0]   freq_lo_lim = FREQ_LO_RST;
  bit [15:0]   freq_hi_lim = FREQ_HI_RST;
  bit [15:0]   dur_lo_lim  = DUR_LO_RST;
  bit [15:0]   dur_hi_lim  = DUR_HI_RST;

  // Limits last written, kept on the stimulus side to aim requests at the accepted band.
  bit [15:0]   band_freq_lo = FREQ_LO_RST;
  bit [15:0]   band_freq_hi = FREQ_HI_RST;
  bit [15:0]   band_dur_lo  = DUR_LO_RST;
  bit [15:0]   band_dur_hi  = DUR_HI_RST;

  tone_result_t results_due [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  bit           steady;
  int unsigned  hold_req;
  int unsigned  hold_served;

  timed_square_tone_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic void go_quiet();
    tone_playing  = 1'b0;
    phase         = '0;
    ms_remaining  = '0;
    ticks_this_ms = '0;
  endfunction

  task automatic tone_step(input logic [REQ_W-1:0] req, input logic [15:0] f,
                           input logic [15:0] d, output tone_result_t res);
    int unsigned quot;
    bit          refuse;
    refuse = 1'b0;
    case (req)
      REQ_TICK: begin
        if (tone_playing) begin
          if (phase >= top_count) phase = '0;
          else phase = phase + 20'd1;
          if (ticks_this_ms == 10'(TICKS_PER_MILLI - 1)) begin
            ticks_this_ms = '0;
            if (ms_remaining != 0) ms_remaining = ms_remaining - 16'd1;
            if (ms_remaining == 0) go_quiet();
          end else begin
            ticks_this_ms = ticks_this_ms + 10'd1;
          end
        end
      end
      REQ_START: begin
        if (f == 0 || f < freq_lo_lim || f > freq_hi_lim ||
            d < dur_lo_lim || d > dur_hi_lim) begin
          refuse = 1'b1;
        end else begin
          quot = TIMER_HZ / 32'(f);
          if (quot == 0) quot = 1;
          top_count     = 20'(quot - 1);
          high_count    = 20'((32'(top_count) + 1) / 2);
          phase         = '0;
          ticks_this_ms = '0;
          ms_remaining  = d;
          tone_playing  = (d != 0);
          if (!tone_playing) go_quiet();
        end
      end
      REQ_STOP: go_quiet();
      default: ;
    endcase
    res.pin     = tone_playing && (phase < high_count);
    res.on      = tone_playing;
    res.refused = refuse;
  endtask

  always @(posedge clk) begin : watch
    tone_result_t want;
    tone_result_t predicted;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FREQ_LO: freq_lo_lim = cfg_wdata;
          CFG_FREQ_HI: freq_hi_lim = cfg_wdata;
          CFG_DUR_LO:  dur_lo_lim  = cfg_wdata;
          CFG_DUR_HI:  dur_hi_lim  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $error("result beat arrived with nothing expected");
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_tdata[0] !== want.pin) begin
            $error("pin_level: expected %0b, got %0b", want.pin, out_tdata[0]);
            error_count++;
          end
          if (out_tdata[1] !== want.on) begin
            $error("tone_on: expected %0b, got %0b", want.on, out_tdata[1]);
            error_count++;
          end
          if (out_tuser !== want.refused) begin
            $error("refused: expected %0b, got %0b", want.refused, out_tuser);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        tone_step(in_tuser, in_tdata[15:0], in_tdata[31:16], predicted);
        results_due.push_back(beat_typed ? beat_want : predicted);
      end
    end
  end

  // Result side: short random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!steady && $urandom_range(99) < 8) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [15:0] f,
                           input logic [15:0] d, input logic typed = 1'b0,
                           input tone_result_t want = '0);
    in_tvalid  <= 1'b1;
    in_tuser   <= req;
    in_tdata   <= {d, f};
    beat_typed <= typed;
    beat_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Limits change only once every beat in flight has come back.
  task automatic apply_limits(input logic [15:0] fl, input logic [15:0] fh,
                              input logic [15:0] dl, input logic [15:0] dh);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_FREQ_LO, fl);
    write_reg(CFG_FREQ_HI, fh);
    write_reg(CFG_DUR_LO, dl);
    write_reg(CFG_DUR_HI, dh);
    cfg_wr_en    <= 1'b0;
    band_freq_lo = fl;
    band_freq_hi = fh;
    band_dur_lo  = dl;
    band_dur_hi  = dh;
  endtask

  // A value near the bottom of an accepted band, or anything at all if the band is empty.
  function automatic logic [15:0] in_band(input logic [15:0] lo, input logic [15:0] hi,
                                          input int unsigned span);
    int unsigned ceiling;
    if (lo > hi) return 16'($urandom);
    ceiling = lo + span;
    if (ceiling > hi) ceiling = hi;
    return 16'($urandom_range(ceiling, lo));
  endfunction

  // A one-millisecond tone followed by enough ticks to run its countdown out.
  task automatic let_tone_expire();
    int unsigned ms;
    ms = 1;
    send_beat(REQ_START, in_band(band_freq_lo, band_freq_hi, 65535), 16'(ms));
    repeat (ms * TICKS_PER_MILLI + $urandom_range(15)) begin
      send_beat(REQ_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic play_random(input int unsigned beats);
    int unsigned sent;
    int unsigned pick;
    logic [15:0] f;
    logic [15:0] d;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) < 7) begin
        pick = $urandom_range(9);
        if (pick < 4) f = 16'($urandom);
        else if (pick < 8) f = in_band(band_freq_lo, band_freq_hi, 65535);
        else f = 16'($urandom_range(2000));
        pick = $urandom_range(9);
        if (pick < 4) d = in_band(band_dur_lo, band_dur_hi, 3);
        else if (pick < 7) d = 16'($urandom);
        else d = 16'($urandom_range(3));
        send_beat(REQ_START, f, d);
        sent++;
        repeat ($urandom_range(40, 1)) begin
          pick = $urandom_range(99);
          if (pick < 4) send_beat(REQ_STOP, 16'($urandom), 16'($urandom));
          else if (pick < 6) send_beat(REQ_SPARE, 16'($urandom), 16'($urandom));
          else if (pick < 9) send_beat(REQ_START, 16'($urandom), 16'($urandom));
          else send_beat(REQ_TICK, 16'($urandom), 16'($urandom));
          sent++;
        end
      end else begin
        send_beat(REQ_W'($urandom_range(3)), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [1:0]  setting_now;
    logic [15:0] fl;
    logic [15:0] dl;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_TICK;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_FREQ_LO;
    cfg_wdata   = '0;
    beat_typed  = 1'b0;
    beat_want   = '0;
    steady      = 1'b0;
    hold_req    = 0;
    hold_served = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    setting_now = SET_RESET;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].setting != setting_now) begin
        setting_now = DIRECTED[i].setting;
        if (setting_now == SET_WIDE) apply_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        else apply_limits(16'd5000, 16'd100, 16'd5000, 16'd10);
      end
      send_beat(DIRECTED[i].req, DIRECTED[i].freq, DIRECTED[i].ms,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    apply_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    // Hold the result side off while beats keep coming, so the block backs up.
    hold_req <= hold_req + 1;
    play_random(80);

    fl = 16'($urandom_range(3000, 1));
    dl = 16'($urandom_range(3));
    steady <= 1'b1;
    apply_limits(fl, 16'($urandom_range(65535, fl)), dl, 16'($urandom_range(8000, dl)));
    play_random(60);
    steady <= 1'b0;
    play_random(50);

    fl = 16'($urandom_range(65535, 2000));
    dl = 16'($urandom_range(65535, 100));
    apply_limits(fl, 16'($urandom_range(fl - 1)), dl, 16'($urandom_range(dl - 1)));
    play_random(20);

    apply_limits(16'd1, 16'hFFFF, 16'd0, 16'd3);
    steady <= 1'b1;
    let_tone_expire();
    steady <= 1'b0;
    play_random(40);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
